>>> rtl/assert_macros.svh
// Assertion macros for the heap queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> rtl/bmh_pkg.sv
// Shared types and constants for the binary max-heap queue.
package bmh_pkg;

  localparam int CAPACITY_DEFAULT  = 64;
  localparam int KEY_WIDTH_DEFAULT = 32;
  localparam int QUEUE_DEPTH       = 2;
  localparam int KEY_PORT_WIDTH    = 32;
  localparam int COUNT_PORT_WIDTH  = 7;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_POP,
    CMD_REPORT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    err_t      err;
  } cmd_ctrl_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_START,
    B_UP,
    B_PUT,
    B_DN_LOAD,
    B_DN,
    B_DONE
  } back_state_t;

endpackage

>>> rtl/bmh_queue.sv
// Small command queue between the front and back parts.
module bmh_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [FW-1:0]    fill;

  assign full     = (fill == FW'(DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rd_ptr];

  // Store an item at the write pointer
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + FW'(1);
      end else if (pop && !push) begin
        fill <= fill - FW'(1);
      end
    end
  end

endmodule

>>> rtl/bmh_front.sv
// Front part: accepts items, tracks the count and classifies each item.
module bmh_front #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                operation,
  input  logic [bmh_pkg::KEY_PORT_WIDTH-1:0]  key_in,
  input  logic                                q_full,
  output logic                                cmd_push,
  output bmh_pkg::cmd_ctrl_t                  cmd_ctrl,
  output logic [KEY_WIDTH-1:0]                cmd_key,
  output logic [$clog2(CAPACITY+1)-1:0]       cmd_count
);
  import bmh_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]                       count;
  logic [KEY_WIDTH+KEY_PORT_WIDTH-1:0] key_wide;

  // Hold off the source while the queue has no room
  assign in_stall = q_full;
  assign cmd_push = in_valid && !q_full;

  // Trim or widen the key to the stored width
  assign key_wide = {{KEY_WIDTH{1'b0}}, key_in};
  assign cmd_key  = key_wide[KEY_WIDTH-1:0];

  // Classify the item against the running count
  always_comb begin
    cmd_ctrl.kind = CMD_REPORT;
    cmd_ctrl.err  = ERR_OK;
    cmd_count     = count;
    if (operation == OP_PUSH) begin
      if (count == CW'(CAPACITY)) begin
        cmd_ctrl.err = ERR_FULL;
      end else begin
        cmd_ctrl.kind = CMD_PUSH;
        cmd_count     = count + CW'(1);
      end
    end else begin
      if (count == '0) begin
        cmd_ctrl.err = ERR_EMPTY;
      end else begin
        cmd_ctrl.kind = CMD_POP;
        cmd_count     = count - CW'(1);
      end
    end
  end

  // Load the count for every accepted item; a full or empty error leaves it unchanged
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd_push) begin
      count <= cmd_count;
    end
  end

endmodule

>>> rtl/bmh_back.sv
// Back part: heap memory, sift sequencer and result register.
`include "assert_macros.svh"

module bmh_back #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  input  bmh_pkg::cmd_ctrl_t                   q_ctrl,
  input  logic [KEY_WIDTH-1:0]                 q_key,
  input  logic [$clog2(CAPACITY+1)-1:0]        q_count,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [bmh_pkg::KEY_PORT_WIDTH-1:0]   top_key,
  output logic [bmh_pkg::COUNT_PORT_WIDTH-1:0] entry_count,
  output logic                                 is_empty,
  output logic [1:0]                           error_code
);
  import bmh_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int LW = IW + 2;

  back_state_t state, state_next;
  cmd_ctrl_t   ctrl;
  logic [CW-1:0]        cnt;
  logic [IW-1:0]        pos, pos_next;
  logic [KEY_WIDTH-1:0] key_hold, key_hold_next;
  logic [KEY_WIDTH-1:0] root_key;

  // Heap memory and its ports
  logic [KEY_WIDTH-1:0] mem [CAPACITY];
  logic                 we, re_a, re_b;
  logic [IW-1:0]        wa, ra, rb;
  logic [KEY_WIDTH-1:0] wd, rd_a, rd_b;

  // Tree navigation
  logic [IW-1:0]        parent_pos, grand_pos, big;
  logic [LW-1:0]        lc, rc, lc2, rc2;
  logic                 lc_ok, rc_ok, lc2_ok, rc2_ok;
  logic [KEY_WIDTH-1:0] big_val;
  logic                 up_swap, dn_stop, out_free;

  logic [KEY_WIDTH+KEY_PORT_WIDTH-1:0] root_wide;
  logic [CW+COUNT_PORT_WIDTH-1:0]      cnt_wide;

  assign parent_pos = (pos - IW'(1)) >> 1;
  assign grand_pos  = (parent_pos - IW'(1)) >> 1;
  assign lc         = {1'b0, pos, 1'b1};
  assign rc         = lc + LW'(1);
  assign lc_ok      = lc < LW'(cnt);
  assign rc_ok      = rc < LW'(cnt);
  assign big        = (rc_ok && (rd_b > rd_a)) ? rc[IW-1:0] : lc[IW-1:0];
  assign big_val    = (rc_ok && (rd_b > rd_a)) ? rd_b : rd_a;
  assign lc2        = {1'b0, big, 1'b1};
  assign rc2        = lc2 + LW'(1);
  assign lc2_ok     = lc2 < LW'(cnt);
  assign rc2_ok     = rc2 < LW'(cnt);
  assign up_swap    = rd_a < key_hold;
  assign dn_stop    = key_hold > big_val;
  assign out_free   = !out_valid || !out_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (!q_empty) state_next = B_START;
      end
      B_START: begin
        case (ctrl.kind)
          CMD_PUSH: state_next = (pos == '0) ? B_DONE : B_UP;
          CMD_POP:  state_next = (cnt != '0) ? B_DN_LOAD : B_DONE;
          default:  state_next = B_DONE;
        endcase
      end
      B_UP: begin
        if (!up_swap)                state_next = B_DONE;
        else if (parent_pos == '0)   state_next = B_PUT;
      end
      B_PUT: state_next = B_DONE;
      B_DN_LOAD: begin
        state_next = lc_ok ? B_DN : B_PUT;
      end
      B_DN: begin
        if (dn_stop)      state_next = B_DONE;
        else if (!lc2_ok) state_next = B_PUT;
      end
      B_DONE: begin
        if (out_free) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Memory controls and datapath updates
  always_comb begin
    q_pop         = 1'b0;
    we            = 1'b0;
    wa            = pos;
    wd            = key_hold;
    re_a          = 1'b0;
    ra            = '0;
    re_b          = 1'b0;
    rb            = '0;
    pos_next      = pos;
    key_hold_next = key_hold;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop         = 1'b1;
          key_hold_next = q_key;
          pos_next      = IW'(q_count - CW'(1));
        end
      end
      B_START: begin
        case (ctrl.kind)
          CMD_PUSH: begin
            if (pos == '0) begin
              we = 1'b1;
            end else begin
              re_a = 1'b1;
              ra   = parent_pos;
            end
          end
          CMD_POP: begin
            pos_next = '0;
            if (cnt != '0) begin
              re_a = 1'b1;
              ra   = cnt[IW-1:0];
            end
          end
          default: ;
        endcase
      end
      B_UP: begin
        we = 1'b1;
        if (up_swap) begin
          wd       = rd_a;
          pos_next = parent_pos;
          if (parent_pos != '0) begin
            re_a = 1'b1;
            ra   = grand_pos;
          end
        end
      end
      B_PUT: begin
        we = 1'b1;
      end
      B_DN_LOAD: begin
        key_hold_next = rd_a;
        if (lc_ok) begin
          re_a = 1'b1;
          ra   = lc[IW-1:0];
          re_b = rc_ok;
          rb   = rc[IW-1:0];
        end
      end
      B_DN: begin
        we = 1'b1;
        if (!dn_stop) begin
          wd       = big_val;
          pos_next = big;
          if (lc2_ok) begin
            re_a = 1'b1;
            ra   = lc2[IW-1:0];
            re_b = rc2_ok;
            rb   = rc2[IW-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // Heap memory with registered reads; mirror the root in a register
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (re_a) rd_a <= mem[ra];
    if (re_b) rd_b <= mem[rb];
    if (we && (wa == '0)) root_key <= wd;
  end

  // Hold the command being worked on
  always_ff @(posedge clk) begin
    pos      <= pos_next;
    key_hold <= key_hold_next;
    if (q_pop) begin
      ctrl <= q_ctrl;
      cnt  <= q_count;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Load the result register; drop valid once the item is taken
  assign root_wide = {{KEY_PORT_WIDTH{1'b0}}, root_key};
  assign cnt_wide  = {{COUNT_PORT_WIDTH{1'b0}}, cnt};

  always_ff @(posedge clk) begin
    if ((state == B_DONE) && out_free) begin
      top_key     <= (cnt != '0) ? root_wide[KEY_PORT_WIDTH-1:0] : '0;
      entry_count <= cnt_wide[COUNT_PORT_WIDTH-1:0];
      is_empty    <= (cnt == '0);
      error_code  <= ctrl.err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == B_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  `ASSERT_IMPL(a_write_live, clk, rst, we, CW'(wa) < cnt)
  `ASSERT_IMPL(a_up_not_root, clk, rst, state == B_UP, pos != '0)
  `ASSERT_IMPL(a_full_count, clk, rst, (state == B_DONE) && (ctrl.err == ERR_FULL), cnt == CW'(CAPACITY))
  `ASSERT_IMPL(a_empty_count, clk, rst, (state == B_DONE) && (ctrl.err == ERR_EMPTY), cnt == '0)
  `ASSERT_NEXT(a_pop_starts, clk, rst, (state == B_IDLE) && !q_empty, state == B_START)

endmodule

>>> rtl/binary_max_heap_priority_queue_core.sv
// Each accepted item passes through the command queue to the sift sequencer, which walks
// one heap level per cycle for push and pop alike, bounded by the single write port of the
// heap memory; the hand-off through the queue comes first.
// The back part works on one item at a time; a stalled result holds the back part and the
// command queue then takes up to two more items before the input stalls.
// Synchronous active-high reset empties the heap and the queue; memory contents are not cleared.
// Top level: front classifier, command queue and heap back end.
module binary_max_heap_priority_queue_core #(
  parameter int CAPACITY  = bmh_pkg::CAPACITY_DEFAULT,
  parameter int KEY_WIDTH = bmh_pkg::KEY_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 operation,
  input  logic [bmh_pkg::KEY_PORT_WIDTH-1:0]   key_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [bmh_pkg::KEY_PORT_WIDTH-1:0]   top_key,
  output logic [bmh_pkg::COUNT_PORT_WIDTH-1:0] entry_count,
  output logic                                 is_empty,
  output logic [1:0]                           error_code
);
  import bmh_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int QW = $bits(cmd_ctrl_t) + KEY_WIDTH + CW;

  logic                 cmd_push, q_full, q_empty, q_pop;
  cmd_ctrl_t            cmd_ctrl, q_ctrl;
  logic [KEY_WIDTH-1:0] cmd_key, q_key;
  logic [CW-1:0]        cmd_count, q_count;
  logic [QW-1:0]        q_data;

  bmh_front #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .key_in    (key_in),
    .q_full    (q_full),
    .cmd_push  (cmd_push),
    .cmd_ctrl  (cmd_ctrl),
    .cmd_key   (cmd_key),
    .cmd_count (cmd_count)
  );

  bmh_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (cmd_push),
    .push_data ({cmd_ctrl, cmd_key, cmd_count}),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  assign {q_ctrl, q_key, q_count} = q_data;

  bmh_back #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .q_ctrl      (q_ctrl),
    .q_key       (q_key),
    .q_count     (q_count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .top_key     (top_key),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .error_code  (error_code)
  );

endmodule

>>> verif/binary_max_heap_priority_queue_core_tb.sv
// Self-checking testbench for the binary max-heap priority queue core.
module binary_max_heap_priority_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bmh_pkg::*;

  localparam int HEAP_CAP     = CAPACITY_DEFAULT;
  localparam int RANDOM_ITEMS = 850;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [KEY_PORT_WIDTH-1:0]   top;
    logic [COUNT_PORT_WIDTH-1:0] count;
    logic                        empty;
    err_t                        err;
  } heap_result_t;

  typedef struct {
    op_t                         op;
    logic [KEY_PORT_WIDTH-1:0]   key;
    bit                          typed;
    logic [KEY_PORT_WIDTH-1:0]   top;
    logic [COUNT_PORT_WIDTH-1:0] count;
    logic                        empty;
    err_t                        err;
  } stim_row_t;

  localparam int DIR_ROWS = 26;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic                         operation;
  logic [KEY_PORT_WIDTH-1:0]    key_in;
  logic                         out_valid;
  logic                         out_stall;
  logic [KEY_PORT_WIDTH-1:0]    top_key;
  logic [COUNT_PORT_WIDTH-1:0]  entry_count;
  logic                         is_empty;
  logic [1:0]                   error_code;

  // Predicted heap contents and live count
  logic [KEY_PORT_WIDTH-1:0]    heap_keys [HEAP_CAP];
  int                           heap_len;
  heap_result_t                 pending_results [$];
  int                           fault_count;

  // Directed rows: typed expectations only where they are plain to see
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{OP_POP,  32'h1234_5678, 1'b1, 32'h0000_0000, 7'd0, 1'b1, ERR_EMPTY},
    '{OP_PUSH, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 7'd1, 1'b0, ERR_OK},
    '{OP_PUSH, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 7'd2, 1'b0, ERR_OK},
    '{OP_PUSH, 32'h8000_0000, 1'b0, '0, '0, 1'b0, ERR_OK},
    '{OP_PUSH, 32'h8000_0000, 1'b0, '0, '0, 1'b0, ERR_OK},
    '{OP_PUSH, 32'h7FFF_FFFF, 1'b0, '0, '0, 1'b0, ERR_OK},
    '{OP_PUSH, 32'h8000_0000, 1'b0, '0, '0, 1'b0, ERR_OK},
    '{OP_PUSH, 32'h5555_5555, 1'b0, '0, '0, 1'b0, ERR_OK},
    '{OP_PUSH, 32'hAAAA_AAAA, 1'b0, '0, '0, 1'b0, ERR_OK},
    '{OP_PUSH, 32'h0000_0001, 1'b0, '0, '0, 1'b0, ERR_OK},
    '{OP_POP,  32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0, ERR_OK},
    '{OP_POP,  32'h0000_0000, 1'b0, '0, '0, 1'b0, ERR_OK},
    '{OP_POP,  32'hA5A5_A5A5, 1'b0, '0, '0, 1'b0, ERR_OK},
    '{OP_POP,  32'h5A5A_5A5A, 1'b0, '0, '0, 1'b0, ERR_OK},
    '{OP_POP,  32'h0000_0000, 1'b0, '0, '0, 1'b0, ERR_OK},
    '{OP_POP,  32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0, ERR_OK},
    '{OP_POP,  32'h0F0F_0F0F, 1'b0, '0, '0, 1'b0, ERR_OK},
    '{OP_POP,  32'hF0F0_F0F0, 1'b0, '0, '0, 1'b0, ERR_OK},
    '{OP_POP,  32'h0000_0000, 1'b0, '0, '0, 1'b0, ERR_OK},
    '{OP_POP,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 7'd0, 1'b1, ERR_EMPTY},
    '{OP_PUSH, 32'h0000_0005, 1'b0, '0, '0, 1'b0, ERR_OK},
    '{OP_PUSH, 32'h0000_0005, 1'b0, '0, '0, 1'b0, ERR_OK},
    '{OP_PUSH, 32'h0000_0005, 1'b0, '0, '0, 1'b0, ERR_OK},
    '{OP_POP,  32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0, ERR_OK},
    '{OP_POP,  32'h0000_0000, 1'b0, '0, '0, 1'b0, ERR_OK},
    '{OP_POP,  32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0, ERR_OK}
  };

  binary_max_heap_priority_queue_core u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .operation   (operation),
    .key_in      (key_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .top_key     (top_key),
    .entry_count (entry_count),
    .is_empty    (is_empty),
    .error_code  (error_code)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one item to the predicted heap and return the result it gives
  task automatic apply_heap_op(input op_t op, input logic [KEY_PORT_WIDTH-1:0] key,
                               output heap_result_t res);
    int pos;
    int up;
    int lc;
    int rc;
    int big;
    logic [KEY_PORT_WIDTH-1:0] tmp;
    res.err = ERR_OK;
    if (op == OP_PUSH) begin
      if (heap_len >= HEAP_CAP) begin
        res.err = ERR_FULL;
      end else begin
        heap_keys[heap_len] = key;
        pos = heap_len;
        heap_len++;
        // Sift up; an equal parent stops the walk
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (!(heap_keys[up] < heap_keys[pos])) break;
          tmp = heap_keys[up];
          heap_keys[up] = heap_keys[pos];
          heap_keys[pos] = tmp;
          pos = up;
        end
      end
    end else begin
      if (heap_len == 0) begin
        res.err = ERR_EMPTY;
      end else begin
        heap_len--;
        heap_keys[0] = heap_keys[heap_len];
        pos = 0;
        // Sift down toward the larger child; the left child wins a tie
        forever begin
          lc = pos * 2 + 1;
          rc = pos * 2 + 2;
          if (lc >= heap_len) break;
          big = lc;
          if (rc < heap_len && heap_keys[rc] > heap_keys[lc]) big = rc;
          if (heap_keys[pos] > heap_keys[big]) break;
          tmp = heap_keys[pos];
          heap_keys[pos] = heap_keys[big];
          heap_keys[big] = tmp;
          pos = big;
        end
      end
    end
    res.top   = (heap_len != 0) ? heap_keys[0] : '0;
    res.count = heap_len[COUNT_PORT_WIDTH-1:0];
    res.empty = (heap_len == 0);
  endtask

  // Offer one item, hold it until taken, then log the expected result
  task automatic offer_item(input op_t op, input logic [KEY_PORT_WIDTH-1:0] key,
                            input bit typed, input heap_result_t typed_res,
                            input bit may_idle);
    heap_result_t res;
    while (may_idle && $urandom_range(0, 99) < 12) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    operation = op;
    key_in    = key;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_heap_op(op, key, res);
    pending_results.insert(pending_results.size(), typed ? typed_res : res);
    @(negedge clk);
  endtask

  // Mix of wide random keys, tight ranges for ties and the extremes
  function automatic logic [KEY_PORT_WIDTH-1:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1: pick_key = $urandom_range(0, 7);
      2: begin
        case ($urandom_range(0, 3))
          0: pick_key = '0;
          1: pick_key = '1;
          2: pick_key = 32'h8000_0000;
          default: pick_key = 32'h7FFF_FFFF;
        endcase
      end
      3: pick_key = 32'hFFFF_FFF0 | $urandom_range(0, 15);
      default: pick_key = $urandom;
    endcase
  endfunction

  // Stimulus: reset, directed table, then random phases
  initial begin
    heap_result_t blank;
    heap_result_t row_res;
    int sent;
    int extra;
    int seg_len;
    int push_pct;
    op_t op;
    blank      = '{top: '0, count: '0, empty: 1'b0, err: ERR_OK};
    rst        = 1'b1;
    in_valid   = 1'b0;
    operation  = 1'b0;
    key_in     = '0;
    heap_len   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      row_res = '{top: dir_rows[i].top, count: dir_rows[i].count,
                  empty: dir_rows[i].empty, err: dir_rows[i].err};
      offer_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].typed, row_res, 1'b1);
    end

    // Random phases: fill past full, drain past empty, or mixed traffic
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: begin
          extra = $urandom_range(1, 4);
          while (heap_len < HEAP_CAP) begin
            offer_item(OP_PUSH, pick_key(), 1'b0, blank, !(sent >= 300 && sent < 450));
            sent++;
          end
          repeat (extra) begin
            offer_item(OP_PUSH, pick_key(), 1'b0, blank, !(sent >= 300 && sent < 450));
            sent++;
          end
        end
        1: begin
          extra = $urandom_range(1, 3);
          while (heap_len > 0) begin
            offer_item(OP_POP, pick_key(), 1'b0, blank, !(sent >= 300 && sent < 450));
            sent++;
          end
          repeat (extra) begin
            offer_item(OP_POP, pick_key(), 1'b0, blank, !(sent >= 300 && sent < 450));
            sent++;
          end
        end
        default: begin
          seg_len  = $urandom_range(20, 60);
          push_pct = $urandom_range(35, 65);
          repeat (seg_len) begin
            op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
            offer_item(op, pick_key(), 1'b0, blank, !(sent >= 300 && sent < 450));
            sent++;
          end
        end
      endcase
    end
    in_valid = 1'b0;

    // Drain, then allow for any stray result
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off, one quiet stretch
  initial begin
    int cyc;
    cyc       = 0;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc >= 1500 && cyc < 1700) begin
        out_stall = 1'b1;
      end else if (cyc >= 2500 && cyc < 4000) begin
        out_stall = 1'b0;
      end else begin
        out_stall = ($urandom_range(0, 99) < 12);
      end
    end
  end

  // Compare each result taken with the oldest expectation
  always @(posedge clk) begin
    heap_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        if (fault_count < 10)
          $display("unexpected result: top_key %h entry_count %0d is_empty %b error_code %0d",
                   top_key, entry_count, is_empty, error_code);
        fault_count++;
      end else begin
        want = pending_results.pop_front();
        if (top_key !== want.top || entry_count !== want.count ||
            is_empty !== want.empty || error_code !== want.err) begin
          if (fault_count < 10)
            $display("mismatch: top_key %h/%h entry_count %0d/%0d is_empty %b/%b err %0d/%0d",
                     want.top, top_key, want.count, entry_count, want.empty, is_empty,
                     want.err, error_code);
          fault_count++;
        end
      end
    end
  end

  initial fault_count = 0;

  // Watchdog
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/bmh_pkg.sv
rtl/bmh_queue.sv
rtl/bmh_front.sv
rtl/bmh_back.sv
rtl/binary_max_heap_priority_queue_core.sv
verif/binary_max_heap_priority_queue_core_tb.sv
